[design/mjt_pkg.sv]
// package: types, constants and saturating helpers for the trajectory unit
package mjt_pkg;

    localparam int unsigned TAU_BITS = 30;
    localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        CFG_STEP  = 4'd0,
        CFG_SPEED = 4'd1,
        CFG_ACCEL = 4'd2,
        CFG_TRACK = 4'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_DIV = 3'd1,
        OP_ADD = 3'd2,
        OP_MOD = 3'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [6:0]         sh;
    } t_alu_req;

    function automatic logic signed [63:0] f_sat(input logic signed [64:0] v);
        logic signed [64:0] hi;
        hi = {LIM[63], LIM};
        if (v > hi) return LIM;
        if (v < -hi) return -LIM;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] f_clip(input logic signed [63:0] v);
        return f_sat({v[63], v});
    endfunction

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], f_clip(a)} + {b[63], f_clip(b)};
        return f_sat(s);
    endfunction

endpackage

[design/mjt_if.sv]
// valid/ready channel interface
interface mjt_if #(
    parameter int W = 32
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/mjt_alu.sv]
// shared multi-cycle unit: saturating shifted multiply, shifted divide, modulo
module mjt_alu (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  mjt_pkg::t_alu_req      i_req,
    output logic                   o_done,
    output logic signed [63:0]     o_res
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_MSH  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_st;

    t_st r_st, n_st;
    mjt_pkg::t_op r_op;
    logic        r_neg;
    logic [63:0] r_ua, r_ub;
    logic [127:0] r_acc;
    logic [6:0]  r_sh;
    logic [1:0]  r_part;
    logic [127:0] r_num;
    logic [63:0] r_rem, r_q;
    logic [7:0]  r_bit;
    logic        r_sat;
    logic signed [63:0] r_res;
    logic        r_done;

    logic [63:0] w_ua, w_ub, w_pp;
    logic [31:0] w_pa, w_pb;
    logic [64:0] w_rem2;
    logic [127:0] w_shifted;
    logic [63:0] w_r;
    logic signed [63:0] w_ca, w_cb;

    assign w_ca = mjt_pkg::f_clip(i_req.a);
    assign w_cb = mjt_pkg::f_clip(i_req.b);
    assign w_ua = w_ca[63] ? 64'(-w_ca) : 64'(w_ca);
    assign w_ub = w_cb[63] ? 64'(-w_cb) : 64'(w_cb);
    assign w_pa = r_part[1] ? r_ua[63:32] : r_ua[31:0];
    assign w_pb = r_part[0] ? r_ub[63:32] : r_ub[31:0];
    assign w_pp = 64'(w_pa) * 64'(w_pb);
    assign w_rem2 = {r_rem, r_num[127]};
    assign w_shifted = r_acc >> r_sh;
    assign w_r = (w_shifted[127:64] != 64'd0 || w_shifted[63:0] > 64'(mjt_pkg::LIM))
                 ? 64'(mjt_pkg::LIM) : w_shifted[63:0];

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_start) begin
                n_st = (i_req.op == mjt_pkg::OP_MUL) ? S_MUL : S_DIV;
            end
            S_MUL:  if (r_part == 2'd3) n_st = S_MSH;
            S_MSH:  n_st = S_IDLE;
            S_DIV:  if (r_bit == 8'd0 || r_sat) n_st = S_FIN;
            S_FIN:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == S_MSH) || (r_st == S_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_op   <= i_req.op;
                r_ua   <= w_ua;
                r_ub   <= (i_req.op == mjt_pkg::OP_MUL) ? w_ub :
                          ((w_ub == 64'd0) ? 64'd1 : w_ub);
                r_sh   <= i_req.sh;
                r_part <= 2'd0;
                r_acc  <= '0;
                r_neg  <= (i_req.op == mjt_pkg::OP_MUL) ? (w_ca[63] ^ w_cb[63]) : w_ca[63];
                r_num  <= {64'd0, w_ua} << i_req.sh[5:0];
                r_rem  <= '0;
                r_q    <= '0;
                r_bit  <= 8'd127;
                r_sat  <= 1'b0;
            end
            S_MUL: begin
                r_acc  <= r_acc + ({64'd0, w_pp} <<
                                   {{1'b0, r_part[1]} + {1'b0, r_part[0]}, 5'd0});
                r_part <= r_part + 2'd1;
            end
            S_MSH: begin
                r_res <= r_neg ? -$signed(w_r) : $signed(w_r);
            end
            S_DIV: begin
                r_num <= {r_num[126:0], 1'b0};
                r_bit <= r_bit - 8'd1;
                if (w_rem2 >= {1'b0, r_ub}) begin
                    r_rem <= 64'(w_rem2 - {1'b0, r_ub});
                    r_q   <= {r_q[62:0], 1'b1};
                    if (r_op == mjt_pkg::OP_DIV &&
                        {r_q[62:0], 1'b1} > 64'(mjt_pkg::LIM)) begin
                        r_sat <= 1'b1;
                        r_q   <= 64'(mjt_pkg::LIM);
                    end
                end else begin
                    r_rem <= w_rem2[63:0];
                    r_q   <= {r_q[62:0], 1'b0};
                    if (r_op == mjt_pkg::OP_DIV &&
                        {r_q[62:0], 1'b0} > 64'(mjt_pkg::LIM)) begin
                        r_sat <= 1'b1;
                        r_q   <= 64'(mjt_pkg::LIM);
                    end
                end
            end
            S_FIN: begin
                if (r_op == mjt_pkg::OP_MOD) begin
                    r_res <= (r_neg && r_rem != 64'd0) ? $signed(r_ub - r_rem)
                                                       : $signed(r_rem);
                end else begin
                    r_res <= r_neg ? -$signed(r_q) : $signed(r_q);
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

[design/min_jerk_trajectory_generator_unit.sv]
// top level: minimum-jerk quintic trajectory generator with sequencer
//
//  channel  | dir | payload
//  i_req    | in  | axis, start/goal pos vel acc, point_count
//  o_pnt    | out | point_pos, point_vel, point_acc, last_point
//  cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// solve takes 7 unit operations, each point 27 more plus a modulo when longitudinal
// a request is taken only when idle; a point waits while the output register is full
// synchronous active-low reset clears control and trajectory history
module min_jerk_trajectory_generator_unit #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mjt_if.sink          i_req,
    mjt_if.source        o_pnt,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ISSUE = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_OUT   = 7'b0001000,
        S_PUSH  = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_st;

    t_st r_st;
    logic [16:0] r_step;
    logic [30:0] r_speed, r_accel, r_track;
    logic        r_lon;
    logic signed [63:0] r_x [0:11];
    logic signed [63:0] r_c [0:5];
    logic signed [63:0] r_v [0:10];
    logic [CW-1:0] r_n, r_i;
    logic [5:0]  r_pc;
    logic        r_start;
    mjt_pkg::t_alu_req r_req;
    logic        w_done;
    logic signed [63:0] w_res;
    logic        r_ov;
    logic [31:0] r_op, r_ovl, r_oa;
    logic        r_ol;

    logic signed [63:0] w_in [0:5];
    logic [6:0] w_cnt_raw;
    logic [CW-1:0] w_cnt;

    mjt_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_req(r_req),
        .o_done(w_done), .o_res(w_res)
    );

    assign w_cnt_raw = i_req.data[6:0];
    assign w_cnt = (32'(w_cnt_raw) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(w_cnt_raw);
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_in[k] = 64'(signed'(i_req.data[7 + 32*(5-k) +: 32]));
        end
    end

    assign i_req.ready = (r_st == S_IDLE);
    assign o_pnt.valid = r_ov;
    assign o_pnt.data  = {r_op, r_ovl, r_oa, r_ol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 17'd1311;
            r_speed <= 31'd1441792;
            r_accel <= 31'd655360;
            r_track <= 31'd455183827;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mjt_pkg::CFG_STEP:  r_step  <= i_cfg_data[16:0];
                mjt_pkg::CFG_SPEED: r_speed <= i_cfg_data;
                mjt_pkg::CFG_ACCEL: r_accel <= i_cfg_data;
                mjt_pkg::CFG_TRACK: r_track <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // micro-program: x registers hold scratch; r_v holds per-point values
    // x0 p0 x1 v0 x2 a0 x3 pf x4 vf x5 af x6 T x7 aT x8 b0 x9 b1 x10 h x11 dt2
    function automatic mjt_pkg::t_alu_req f_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int s);
        mjt_pkg::t_alu_req q;
        q.op = mjt_pkg::OP_MUL; q.a = a; q.b = b; q.sh = 7'(s);
        return q;
    endfunction
    function automatic mjt_pkg::t_alu_req f_div(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int s);
        mjt_pkg::t_alu_req q;
        q.op = mjt_pkg::OP_DIV; q.a = a; q.b = b; q.sh = 7'(s);
        return q;
    endfunction

    // v0 tau v1 pos v2 vt v3 at2 v4 vel v5 acc v6 tmp v7 cap v8 pp v9 pv v10 pa
    logic signed [63:0] w_dt, w_tau_num;
    logic signed [63:0] w_k;
    mjt_pkg::t_alu_req w_req;
    assign w_dt = 64'(r_step == 17'd0 ? 17'd1 : (r_step > 17'd65536 ? 17'd65536 : r_step));
    assign w_tau_num = 64'(r_i) <<< mjt_pkg::TAU_BITS;

    always_comb begin
        w_req = f_mul(r_x[6], 64'sd0, 0);
        w_k = '0;
        unique case (r_pc)
            6'd0:  w_req = f_mul(r_x[2], r_x[6], FRAC_BITS);
            6'd1:  w_req = f_mul(r_x[1], r_x[6], FRAC_BITS);
            6'd2:  w_req = f_mul(r_x[7], r_x[6], FRAC_BITS + 1);
            6'd3:  w_req = f_mul(mjt_pkg::f_sadd(mjt_pkg::f_sadd(r_x[4], -r_x[1]), -r_x[7]),
                                 r_x[6], FRAC_BITS);
            6'd4:  w_req = f_mul(mjt_pkg::f_sadd(r_x[5], -r_x[2]), r_x[6], FRAC_BITS);
            6'd5:  w_req = f_mul(r_x[10], r_x[6], FRAC_BITS + 1);
            6'd6:  w_req = f_mul(w_dt, w_dt, FRAC_BITS);
            6'd7:  w_req = f_div(w_tau_num, 64'(r_n), 0);
            6'd8, 6'd9, 6'd10, 6'd11, 6'd12:
                   w_req = f_mul(r_v[1], r_v[0], mjt_pkg::TAU_BITS);
            6'd13: w_req = f_mul(r_c[5], 64'sd5, 0);
            6'd14, 6'd16, 6'd18, 6'd20: begin
                   w_k = 64'(6'd4 - 6'((r_pc - 6'd14) >> 1));
                   w_req = f_mul(r_c[w_k[2:0]], w_k, 0);
            end
            6'd15, 6'd17, 6'd19, 6'd21:
                   w_req = f_mul(r_v[2], r_v[0], mjt_pkg::TAU_BITS);
            6'd22: w_req = f_mul(r_c[5], 64'sd20, 0);
            6'd23, 6'd25, 6'd27: begin
                   w_k = 64'(6'd4 - 6'((r_pc - 6'd23) >> 1));
                   w_req = f_mul(r_c[w_k[2:0]],
                                 64'({1'b0, w_k[2:0]} * ({1'b0, w_k[2:0]} - 4'd1)), 0);
            end
            6'd24, 6'd26, 6'd28:
                   w_req = f_mul(r_v[3], r_v[0], mjt_pkg::TAU_BITS);
            6'd29: w_req = f_div(r_v[2], r_x[6], FRAC_BITS);
            6'd30: w_req = f_div(r_v[3], r_x[6], FRAC_BITS);
            6'd31: w_req = f_div(r_v[5], r_x[6], FRAC_BITS);
            6'd32: w_req = f_mul(r_v[9], w_dt, FRAC_BITS);
            6'd33: w_req = f_mul(r_v[10], r_x[11], FRAC_BITS + 1);
            6'd34: begin
                   w_req = f_div(r_v[8], 64'(r_track == 31'd0 ? 31'd1 : r_track), 0);
                   w_req.op = mjt_pkg::OP_MOD;
            end
            default: ;
        endcase
    end

    logic signed [63:0] w_pos, w_vel, w_acc, w_p48;
    logic signed [63:0] w_l32, w_spd, w_acl;
    assign w_l32 = 64'sh7FFF_FFFF;
    assign w_spd = $signed({33'd0, r_speed});
    assign w_acl = $signed({33'd0, r_accel});

    always_comb begin
        w_pos = r_v[1];
        w_vel = r_v[4];
        w_acc = r_v[5];
        if (r_lon) begin
            if (w_pos > r_v[7]) w_pos = r_v[7];
            if (w_vel > w_spd) w_vel = w_spd;
            if (w_acc > w_acl) w_acc = w_acl;
            if (w_acc < -w_acl) w_acc = -w_acl;
        end
        w_p48 = (w_pos > 64'sh7FFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF :
                (w_pos < -64'sh8000_0000_0000) ? -64'sh8000_0000_0000 : w_pos;
        w_vel = (w_vel > w_l32) ? w_l32 : ((w_vel < -w_l32 - 1) ? -w_l32 - 1 : w_vel);
        w_acc = (w_acc > w_l32) ? w_l32 : ((w_acc < -w_l32 - 1) ? -w_l32 - 1 : w_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
            r_pc    <= '0;
            r_v[8]  <= '0;
            r_v[9]  <= '0;
            r_v[10] <= '0;
        end else begin
            r_start <= 1'b0;
            if (o_pnt.valid && o_pnt.ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_req.valid) begin
                    r_lon <= ~i_req.data[199];
                    for (int k = 0; k < 6; k++) r_x[k] <= w_in[k];
                    r_n  <= w_cnt;
                    r_x[6] <= 64'(24'(w_cnt) * 24'(w_dt[16:0]));
                    r_i  <= CW'(1);
                    r_pc <= 6'd0;
                    if (w_cnt != '0) r_st <= S_ISSUE;
                end
                S_ISSUE: begin
                    r_req   <= w_req;
                    r_start <= 1'b1;
                    r_st    <= S_WAIT;
                end
                S_WAIT: if (w_done) begin
                    r_st <= S_ISSUE;
                    r_pc <= r_pc + 6'd1;
                    unique case (r_pc)
                        6'd0: r_x[7] <= w_res;
                        6'd1: r_c[1] <= w_res;
                        6'd2: begin
                            r_c[2] <= w_res;
                            r_c[0] <= r_x[0];
                            r_x[8] <= mjt_pkg::f_sadd(mjt_pkg::f_sadd(r_x[3], -r_x[0]),
                                      -mjt_pkg::f_sadd(r_c[1], w_res));
                        end
                        6'd3: r_x[9] <= w_res;
                        6'd4: r_x[10] <= w_res;
                        6'd5: begin
                            r_x[10] <= w_res;
                            r_c[3] <= mjt_pkg::f_sadd(mjt_pkg::f_sadd(r_x[8] * 10,
                                      -(r_x[9] * 4)), w_res);
                            r_c[4] <= mjt_pkg::f_sadd(mjt_pkg::f_sadd(-(r_x[8] * 15),
                                      r_x[9] * 7), -(w_res * 2));
                            r_c[5] <= mjt_pkg::f_sadd(mjt_pkg::f_sadd(r_x[8] * 6,
                                      -(r_x[9] * 3)), w_res);
                        end
                        6'd6: begin
                            r_x[11] <= w_res;
                            r_v[8]  <= r_x[0];
                            r_v[9]  <= r_x[1];
                            r_v[10] <= r_x[2];
                        end
                        6'd7: begin r_v[0] <= w_res; r_v[1] <= r_c[5]; end
                        6'd8, 6'd9, 6'd10, 6'd11, 6'd12:
                            r_v[1] <= mjt_pkg::f_sadd(w_res, r_c[3'(6'd12 - r_pc)]);
                        6'd13: r_v[2] <= w_res;
                        6'd14, 6'd16, 6'd18, 6'd20: r_v[6] <= w_res;
                        6'd15, 6'd17, 6'd19, 6'd21:
                            r_v[2] <= mjt_pkg::f_sadd(w_res, r_v[6]);
                        6'd22: r_v[3] <= w_res;
                        6'd23, 6'd25, 6'd27: r_v[6] <= w_res;
                        6'd24, 6'd26, 6'd28:
                            r_v[3] <= mjt_pkg::f_sadd(w_res, r_v[6]);
                        6'd29: r_v[4] <= w_res;
                        6'd30: r_v[5] <= w_res;
                        6'd31: r_v[5] <= w_res;
                        6'd32: r_v[6] <= w_res;
                        6'd33: begin
                            r_v[7] <= mjt_pkg::f_sadd(r_v[8], mjt_pkg::f_sadd(r_v[6], w_res));
                            r_st <= S_OUT;
                        end
                        6'd34: begin
                            r_op <= w_res[31:0];
                            r_st <= S_PUSH;
                        end
                        default: ;
                    endcase
                end
                S_OUT: if (!r_ov || o_pnt.ready) begin
                    r_v[8]  <= w_p48;
                    r_v[9]  <= w_vel;
                    r_v[10] <= w_acc;
                    r_ovl   <= w_vel[31:0];
                    r_oa    <= w_acc[31:0];
                    r_ol    <= (r_i == r_n);
                    if (r_lon) begin
                        r_pc <= 6'd34;
                        r_st <= S_ISSUE;
                    end else begin
                        r_op <= (w_p48 > w_l32) ? 32'h7FFF_FFFF :
                                (w_p48 < -w_l32 - 1) ? 32'h8000_0000 : w_p48[31:0];
                        r_st <= S_PUSH;
                    end
                end
                S_PUSH: if (!r_ov || o_pnt.ready) begin
                    r_ov <= 1'b1;
                    r_st <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_i == r_n) begin
                        r_st <= S_DONE;
                    end else begin
                        r_i  <= r_i + CW'(1);
                        r_pc <= 6'd7;
                        r_st <= S_ISSUE;
                    end
                end
                S_DONE: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[design/mjt_checker.sv]
// port-level checker for the trajectory unit, bound to the top level
module mjt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic [6:0]   in_cnt,
    input logic         out_valid,
    input logic         out_ready,
    input logic [96:0]  out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_cnt != 7'd0 |=> !in_ready)
        else $error("request taken while busy");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data[0] |-> !in_ready)
        else $error("idle before last point");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
endmodule

bind min_jerk_trajectory_generator_unit mjt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready), .in_cnt(i_req.data[6:0]),
    .out_valid(o_pnt.valid), .out_ready(o_pnt.ready), .out_data(o_pnt.data[96:0])
);
